// File: hw/rtl/acache_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acache_pkg
// Shared types and constants for the associative cache with FIFO, LRU and
// LFU replacement.
// ----------------------------------------------------------------------------
package acache_pkg;

    // Width of the key as it appears on the ports.
    localparam int PORT_KEY_W = 32;
    localparam int SLOT_W     = 3;
    localparam int COUNT_W    = 16;
    localparam int STAMP_W    = 32;
    localparam int TOTAL_W    = 32;
    localparam int POLICY_W   = 2;

    localparam logic [POLICY_W-1:0] POLICY_FIFO = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_LRU  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_LFU  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_key;
        logic lookup;
        logic update;
    } acache_cmd_t;

endpackage : acache_pkg
`default_nettype wire

// File: hw/rtl/acache_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acache_ctrl
// Sequencer for one access: latch the key, look it up, then update the row.
// ----------------------------------------------------------------------------
module acache_ctrl
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    output acache_pkg::acache_cmd_t       cmd
);
    import acache_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_LOOKUP = 3'b010,
        ST_UPDATE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A new key may enter during the update cycle of the previous one.
    assign busy   = (state_reg == ST_LOOKUP);
    assign accept = start && !busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = accept ? ST_LOOKUP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cmd.load_key = accept;
    assign cmd.lookup   = (state_reg == ST_LOOKUP);
    assign cmd.update   = (state_reg == ST_UPDATE);

endmodule : acache_ctrl
`default_nettype wire

// File: hw/rtl/acache_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acache_dp
// Entry row, parallel tag compare, victim search tree, shift and write back,
// hit and miss totals, and the result registers.
// ----------------------------------------------------------------------------
module acache_dp
#(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 32
)
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire acache_pkg::acache_cmd_t                  cmd,
    input  wire logic [acache_pkg::PORT_KEY_W-1:0]        access_key,
    input  wire logic                                     cfg_we,
    input  wire logic [acache_pkg::POLICY_W-1:0]          cfg_data,
    output logic                                          done,
    output logic                                          hit,
    output logic [acache_pkg::SLOT_W-1:0]                 slot,
    output logic                                          evicted_valid,
    output logic [acache_pkg::PORT_KEY_W-1:0]             evicted_key,
    output logic [acache_pkg::TOTAL_W-1:0]                hit_total,
    output logic [acache_pkg::TOTAL_W-1:0]                miss_total
);
    import acache_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int LVL   = IDX_W;
    localparam int PAD   = 1 << LVL;
    localparam int TOP   = ENTRIES - 1;
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TOP);

    // Entry row.
    logic [ENTRIES-1:0]  valid_reg;
    logic [ENTRIES-1:0]  valid_next;
    logic [KEY_BITS-1:0] key_reg    [ENTRIES];
    logic [KEY_BITS-1:0] key_next   [ENTRIES];
    logic [COUNT_W-1:0]  count_reg  [ENTRIES];
    logic [COUNT_W-1:0]  count_next [ENTRIES];
    logic [STAMP_W-1:0]  stamp_reg  [ENTRIES];
    logic [STAMP_W-1:0]  stamp_next [ENTRIES];

    logic [STAMP_W-1:0]  seq_reg;
    logic [STAMP_W-1:0]  seq_next;
    logic [TOTAL_W-1:0]  hits_reg;
    logic [TOTAL_W-1:0]  hits_next;
    logic [TOTAL_W-1:0]  misses_reg;
    logic [TOTAL_W-1:0]  misses_next;
    logic [POLICY_W-1:0] policy_reg;

    logic [KEY_BITS-1:0] cur_key_reg;

    // Lookup results held for the update cycle.
    logic                found_reg;
    logic [IDX_W-1:0]    found_idx_reg;
    logic [IDX_W-1:0]    vict_reg;
    logic                shift_reg;
    logic                ev_valid_reg;
    logic [KEY_BITS-1:0] ev_key_reg;

    // Result registers.
    logic                done_reg;
    logic                hit_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic                out_ev_valid_reg;
    logic [PORT_KEY_W-1:0] out_ev_key_reg;

    // Lookup logic.
    logic [ENTRIES-1:0]  match;
    logic                found_any;
    logic [IDX_W-1:0]    found_idx;
    logic [IDX_W-1:0]    vict_idx;
    logic                use_search;
    logic                use_stamp;

    // Victim search tree; an invalid entry carries a zero top bit and so
    // always beats a valid one, and ties keep the left (lower) index.
    logic [STAMP_W:0]    tv [LVL+1][PAD];
    logic [IDX_W-1:0]    ti [LVL+1][PAD];

    always_comb
    begin
        use_search = 1'b0;
        use_stamp  = 1'b0;
        unique case (policy_reg)
            POLICY_LRU:
            begin
                use_search = 1'b1;
                use_stamp  = 1'b1;
            end
            POLICY_LFU:
            begin
                use_search = 1'b1;
            end
            default:
            begin
                use_search = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = valid_reg[i] && (key_reg[i] == cur_key_reg);
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                found_idx = IDX_W'(i);
            end
        end
        found_any = |match;
    end

    always_comb
    begin
        for (int l = 0; l <= LVL; l++)
        begin
            for (int p = 0; p < PAD; p++)
            begin
                tv[l][p] = '1;
                ti[l][p] = '0;
            end
        end
        for (int p = 0; p < ENTRIES; p++)
        begin
            tv[0][p] = use_stamp ? {valid_reg[p], stamp_reg[p]}
                                 : {valid_reg[p], (STAMP_W - COUNT_W)'(0), count_reg[p]};
            ti[0][p] = IDX_W'(p);
        end
        for (int p = ENTRIES; p < PAD; p++)
        begin
            ti[0][p] = IDX_W'(p);
        end
        for (int l = 0; l < LVL; l++)
        begin
            for (int p = 0; p < (PAD >> (l + 1)); p++)
            begin
                if (tv[l][2*p+1] < tv[l][2*p])
                begin
                    tv[l+1][p] = tv[l][2*p+1];
                    ti[l+1][p] = ti[l][2*p+1];
                end
                else
                begin
                    tv[l+1][p] = tv[l][2*p];
                    ti[l+1][p] = ti[l][2*p];
                end
            end
        end
        vict_idx = use_search ? ti[LVL][0] : '0;
    end

    // Next state of the row; only the update cycle changes it.
    always_comb
    begin
        valid_next  = valid_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        stamp_next  = stamp_reg;
        seq_next    = seq_reg;
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (cmd.update)
        begin
            if (found_reg)
            begin
                if (hits_reg != '1)
                begin
                    hits_next = hits_reg + TOTAL_W'(1);
                end
                if (count_reg[found_idx_reg] != '1)
                begin
                    count_next[found_idx_reg] = count_reg[found_idx_reg] + COUNT_W'(1);
                end
                stamp_next[found_idx_reg] = seq_reg;
            end
            else
            begin
                if (misses_reg != '1)
                begin
                    misses_next = misses_reg + TOTAL_W'(1);
                end
                if (shift_reg)
                begin
                    for (int i = 0; i < TOP; i++)
                    begin
                        if (IDX_W'(i) >= vict_reg)
                        begin
                            valid_next[i] = valid_reg[i+1];
                            key_next[i]   = key_reg[i+1];
                            count_next[i] = count_reg[i+1];
                            stamp_next[i] = stamp_reg[i+1];
                        end
                    end
                end
                valid_next[TOP] = 1'b1;
                key_next[TOP]   = cur_key_reg;
                count_next[TOP] = COUNT_W'(1);
                stamp_next[TOP] = seq_reg;
            end
            if (seq_reg != '1)
            begin
                seq_next = seq_reg + STAMP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            seq_reg    <= STAMP_W'(1);
            hits_reg   <= '0;
            misses_reg <= '0;
            policy_reg <= POLICY_FIFO;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            seq_reg    <= seq_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            done_reg   <= cmd.update;
            if (cfg_we)
            begin
                policy_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
        stamp_reg <= stamp_next;
        if (cmd.load_key)
        begin
            cur_key_reg <= KEY_BITS'(access_key);
        end
        if (cmd.lookup)
        begin
            found_reg     <= found_any;
            found_idx_reg <= found_idx;
            vict_reg      <= vict_idx;
            shift_reg     <= !found_any && valid_reg[TOP];
            ev_valid_reg  <= !found_any && valid_reg[TOP] && valid_reg[vict_idx];
            ev_key_reg    <= key_reg[vict_idx];
        end
        if (cmd.update)
        begin
            hit_reg          <= found_reg;
            slot_reg         <= SLOT_W'(found_reg ? found_idx_reg : TOP_IDX);
            out_ev_valid_reg <= ev_valid_reg;
            out_ev_key_reg   <= ev_valid_reg ? PORT_KEY_W'(ev_key_reg) : '0;
        end
    end

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_key   = out_ev_key_reg;
    assign hit_total     = hits_reg;
    assign miss_total    = misses_reg;

endmodule : acache_dp
`default_nettype wire

// File: hw/rtl/assoc_cache_with_fifo_lru_lfu.sv
`default_nettype none
// An accepted start passes through the lookup state and then the update state;
// done rises as the update state ends, together with the result registers.
// A new start is taken during the update cycle of the previous access, and
// busy is high only in the lookup cycle.
// Reset empties every entry, clears the totals and selects FIFO replacement.
// ----------------------------------------------------------------------------
// assoc_cache_with_fifo_lru_lfu
// Fully associative cache directory with selectable replacement policy.
// ----------------------------------------------------------------------------
module assoc_cache_with_fifo_lru_lfu
#(
    parameter int ENTRIES  = 8,
    parameter int KEY_BITS = 32
)
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [acache_pkg::PORT_KEY_W-1:0]    access_key,
    output logic                                      done,
    output logic                                      hit,
    output logic [acache_pkg::SLOT_W-1:0]             slot,
    output logic                                      evicted_valid,
    output logic [acache_pkg::PORT_KEY_W-1:0]         evicted_key,
    output logic [acache_pkg::TOTAL_W-1:0]            hit_total,
    output logic [acache_pkg::TOTAL_W-1:0]            miss_total,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [acache_pkg::POLICY_W-1:0]      cfg_data
);
    import acache_pkg::*;

    acache_cmd_t cmd;

    // The policy register takes a beat in any cycle.
    assign cfg_ready = 1'b1;

    acache_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    acache_dp
    #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .access_key    (access_key),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .hit           (hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_key   (evicted_key),
        .hit_total     (hit_total),
        .miss_total    (miss_total)
    );

endmodule : assoc_cache_with_fifo_lru_lfu
`default_nettype wire

// File: hw/rtl/acache_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// acache_chk
// Port-level checks of the cache sequencing and result consistency.
// ----------------------------------------------------------------------------
module acache_chk
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic        done,
    input  wire logic        hit,
    input  wire logic        evicted_valid,
    input  wire logic [31:0] evicted_key
);

    // An accepted access occupies exactly one busy cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not follow an accepted start");

    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held for more than one cycle");

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##2 done)
        else $error("result strobe missing after accepted start");

    // A hit never removes an entry, and a result without a removal reports a zero key.
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit) |-> !evicted_valid)
        else $error("eviction reported on a hit");

    a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !evicted_valid) |-> (evicted_key == 32'd0))
        else $error("evicted_key nonzero without eviction");

endmodule : acache_chk

bind assoc_cache_with_fifo_lru_lfu acache_chk u_acache_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_key   (evicted_key)
);
`default_nettype wire
